// ===== src/crr_pkg.sv =====
// Shared constants, stage payload types and sine table for the circle/box hit test.
package crr_pkg;

  localparam int COORD_BITS = 24;             // signed coordinate width
  localparam int ANGLE_BITS = 16;             // angle code width, one turn
  localparam int EXT_BITS   = COORD_BITS - 1; // unsigned size / radius width
  localparam int DIFF_BITS  = COORD_BITS + 1; // center difference
  localparam int TRIG_BITS  = 16;             // signed Q1.14, holds +/-16384
  localparam int PROD_BITS  = DIFF_BITS + TRIG_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int ROT_SHIFT  = 13;             // Q.(F+14) down to Q.(F+1)
  localparam int LOC_BITS   = SUM_BITS - ROT_SHIFT;
  localparam int RAD_BITS   = COORD_BITS;     // doubled radius
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int LATENCY    = 6;              // accept to strobe, in cycles

  // round(16384*sin(k*pi/128)), k = 0..64
  localparam logic [14:0] QSIN [0:64] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
    15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
    15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
    15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
    15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
    15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
    15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
    15'd16384
  };

  typedef struct packed {
    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic signed [TRIG_BITS-1:0] cosv;
    logic signed [TRIG_BITS-1:0] sinv;
    logic [EXT_BITS-1:0]         hw;
    logic [EXT_BITS-1:0]         hh;
    logic [RAD_BITS-1:0]         rad2;
  } front_t;

  typedef struct packed {
    logic signed [LOC_BITS-1:0] lx;
    logic signed [LOC_BITS-1:0] ly;
    logic [EXT_BITS-1:0]        hw;
    logic [EXT_BITS-1:0]        hh;
    logic [RAD_BITS-1:0]        rad2;
  } local_t;

  // Position within a quarter wave (0..16384) to Q1.14 magnitude, linear interp.
  function automatic logic [14:0] quarter_lookup(input logic [14:0] pos);
    logic [6:0]  idx;
    logic [7:0]  frac;
    logic [14:0] base;
    logic [14:0] upper;
    logic [16:0] prod;
    idx   = pos[14:8];
    frac  = pos[7:0];
    base  = QSIN[7'(idx[5:0])];
    upper = QSIN[7'(idx[5:0]) + 7'd1];
    prod  = 17'(upper - base) * 17'(frac);
    if (idx[6]) return QSIN[64];
    return base + 15'(prod[16:8]);
  endfunction

  // 16-bit phase of one full turn to signed Q1.14 sine.
  function automatic logic signed [TRIG_BITS-1:0] sine16(input logic [15:0] phase);
    logic [14:0]                 pos;
    logic signed [TRIG_BITS-1:0] mag;
    pos = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    mag = TRIG_BITS'(quarter_lookup(pos));
    return phase[15] ? -mag : mag;
  endfunction

endpackage

// ===== src/crr_front.sv =====
// Stage 1: center difference, sine/cosine lookup, size and radius alignment.
module crr_front import crr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] circle_x,
  input  logic signed [COORD_BITS-1:0] circle_y,
  input  logic [EXT_BITS-1:0]          circle_radius,
  input  logic signed [COORD_BITS-1:0] box_x,
  input  logic signed [COORD_BITS-1:0] box_y,
  input  logic [EXT_BITS-1:0]          box_width,
  input  logic [EXT_BITS-1:0]          box_height,
  input  logic [ANGLE_BITS-1:0]        box_angle,
  output logic                         front_valid,
  output front_t                       front
);

  localparam int PHASE_SHIFT = 16 - ANGLE_BITS;

  logic        valid_r;
  front_t      data_r;
  front_t      data_nxt;
  logic [15:0] phase;

  always_comb begin
    phase          = 16'(box_angle) << PHASE_SHIFT;
    data_nxt.dx    = DIFF_BITS'(circle_x) - DIFF_BITS'(box_x);
    data_nxt.dy    = DIFF_BITS'(circle_y) - DIFF_BITS'(box_y);
    data_nxt.sinv  = sine16(phase);
    data_nxt.cosv  = sine16(phase + 16'd16384);
    // in Q.(F+1) the half extents are the full sizes, the radius doubles
    data_nxt.hw    = box_width;
    data_nxt.hh    = box_height;
    data_nxt.rad2  = {circle_radius, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= in_valid;
    data_r <= data_nxt;
  end

  assign front_valid = valid_r;
  assign front       = data_r;

endmodule

// ===== src/crr_rotate.sv =====
// Stages 2-3: rotate the difference by the negative angle and round to Q.(F+1).
module crr_rotate import crr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   front_valid,
  input  front_t front,
  output logic   loc_valid,
  output local_t loc
);

  localparam logic signed [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(1) << (ROT_SHIFT - 1);

  logic                        mul_valid_r;
  logic signed [PROD_BITS-1:0] xc_r, ys_r, yc_r, xs_r;
  logic [EXT_BITS-1:0]         hw_r, hh_r;
  logic [RAD_BITS-1:0]         rad2_r;

  logic                        loc_valid_r;
  local_t                      loc_r;
  local_t                      loc_nxt;
  logic signed [SUM_BITS-1:0]  sum_x, sum_y;

  // upper bits of the biased sum: floor shift, ties toward plus infinity
  always_comb begin
    sum_x        = SUM_BITS'(xc_r) + SUM_BITS'(ys_r) + ROUND_BIAS;
    sum_y        = SUM_BITS'(yc_r) - SUM_BITS'(xs_r) + ROUND_BIAS;
    loc_nxt.lx   = sum_x[SUM_BITS-1:ROT_SHIFT];
    loc_nxt.ly   = sum_y[SUM_BITS-1:ROT_SHIFT];
    loc_nxt.hw   = hw_r;
    loc_nxt.hh   = hh_r;
    loc_nxt.rad2 = rad2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      loc_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= front_valid;
      loc_valid_r <= mul_valid_r;
    end
    xc_r   <= front.dx * front.cosv;
    ys_r   <= front.dy * front.sinv;
    yc_r   <= front.dy * front.cosv;
    xs_r   <= front.dx * front.sinv;
    hw_r   <= front.hw;
    hh_r   <= front.hh;
    rad2_r <= front.rad2;
    loc_r  <= loc_nxt;
  end

  assign loc_valid = loc_valid_r;
  assign loc       = loc_r;

endmodule

// ===== src/crr_test.sv =====
// Stages 4-6: clamp to the box, coarse range check, squared distance test.
module crr_test import crr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   loc_valid,
  input  local_t loc,
  output logic   out_valid,
  output logic   out_hit
);

  logic                       err_valid_r;
  logic [RAD_BITS-1:0]        ax_r, ay_r, rad_r;
  logic                       near_r;

  logic                       sq_valid_r;
  logic [SQ_BITS-1:0]         sx_r, sy_r, r2_r;
  logic                       sq_near_r;

  logic                       hit_valid_r;
  logic                       hit_r;

  logic signed [LOC_BITS-1:0] hw_s, hh_s, ex, ey;
  logic [LOC_BITS-1:0]        ax, ay;
  logic                       near_nxt;

  always_comb begin
    hw_s = $signed(LOC_BITS'(loc.hw));
    hh_s = $signed(LOC_BITS'(loc.hh));
    // distance from the clamped point
    if (loc.lx > hw_s)       ex = loc.lx - hw_s;
    else if (loc.lx < -hw_s) ex = loc.lx + hw_s;
    else                     ex = '0;
    if (loc.ly > hh_s)       ey = loc.ly - hh_s;
    else if (loc.ly < -hh_s) ey = loc.ly + hh_s;
    else                     ey = '0;
    ax = ex[LOC_BITS-1] ? LOC_BITS'(-ex) : LOC_BITS'(ex);
    ay = ey[LOC_BITS-1] ? LOC_BITS'(-ey) : LOC_BITS'(ey);
    // a component beyond the radius is a miss; keeps the squares narrow
    near_nxt = (ax <= LOC_BITS'(loc.rad2)) && (ay <= LOC_BITS'(loc.rad2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_valid_r <= 1'b0;
      sq_valid_r  <= 1'b0;
      hit_valid_r <= 1'b0;
    end else begin
      err_valid_r <= loc_valid;
      sq_valid_r  <= err_valid_r;
      hit_valid_r <= sq_valid_r;
    end
    ax_r      <= RAD_BITS'(ax);
    ay_r      <= RAD_BITS'(ay);
    rad_r     <= loc.rad2;
    near_r    <= near_nxt;
    sx_r      <= SQ_BITS'(ax_r) * SQ_BITS'(ax_r);
    sy_r      <= SQ_BITS'(ay_r) * SQ_BITS'(ay_r);
    r2_r      <= SQ_BITS'(rad_r) * SQ_BITS'(rad_r);
    sq_near_r <= near_r;
    hit_r     <= sq_near_r && ((SQ_BITS + 1)'(sx_r) + (SQ_BITS + 1)'(sy_r)
                               <= (SQ_BITS + 1)'(r2_r));
  end

  assign out_valid = hit_valid_r;
  assign out_hit   = hit_r;

endmodule

// ===== src/circle_rotated_rect_collision.sv =====
// Top level of the circle versus rotated rectangle hit test pipeline.
//
// Use:
//   Drive the circle (center, radius) and the box (center, full width and
//   height, angle in 1/65536 turn) on the in_ ports and raise start. An item
//   is taken at each rising edge with start high and busy low. Coordinates
//   are signed Q16.8, sizes and radius unsigned Q15.8.
//   busy is low whenever rst_n is high, so one item can be taken every
//   clock: throughput is one item per cycle, with no gaps between items.
//   Each item gives one result: out_valid is high for exactly one cycle,
//   after passing the six register stages, with out_hit = 1 when the circle
//   touches or overlaps the box. Results leave in input order.
//   Latency is set by six register stages: difference and sine/cosine
//   lookup, the four rotation products, sum and rounding, clamp and range
//   check, the three squares, and the final compare.
//   Reset (synchronous, active low) clears every stage's valid bit, so no
//   strobe follows reset; busy stays high while reset is held.
//   The receiver cannot stall: a result not taken in its strobe cycle is gone.
module circle_rotated_rect_collision import crr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_circle_x,
  input  logic signed [COORD_BITS-1:0] in_circle_y,
  input  logic [EXT_BITS-1:0]          in_circle_radius,
  input  logic signed [COORD_BITS-1:0] in_box_x,
  input  logic signed [COORD_BITS-1:0] in_box_y,
  input  logic [EXT_BITS-1:0]          in_box_width,
  input  logic [EXT_BITS-1:0]          in_box_height,
  input  logic [ANGLE_BITS-1:0]        in_box_angle,
  output logic                         out_valid,
  output logic                         out_hit
);

  logic   accept;
  logic   front_valid;
  front_t front;
  logic   loc_valid;
  local_t loc;

  // no backpressure anywhere; only reset blocks the input
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  crr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (accept),
    .circle_x      (in_circle_x),
    .circle_y      (in_circle_y),
    .circle_radius (in_circle_radius),
    .box_x         (in_box_x),
    .box_y         (in_box_y),
    .box_width     (in_box_width),
    .box_height    (in_box_height),
    .box_angle     (in_box_angle),
    .front_valid   (front_valid),
    .front         (front)
  );

  crr_rotate u_rotate (
    .clk         (clk),
    .rst_n       (rst_n),
    .front_valid (front_valid),
    .front       (front),
    .loc_valid   (loc_valid),
    .loc         (loc)
  );

  crr_test u_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .loc_valid (loc_valid),
    .loc       (loc),
    .out_valid (out_valid),
    .out_hit   (out_hit)
  );

endmodule

// ===== src/crr_checker.sv =====
// Port-level checks for the hit test pipeline, bound to the top level.
module crr_checker import crr_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic signed [COORD_BITS-1:0] in_circle_x,
  input logic signed [COORD_BITS-1:0] in_circle_y,
  input logic signed [COORD_BITS-1:0] in_box_x,
  input logic signed [COORD_BITS-1:0] in_box_y,
  input logic                         out_valid,
  input logic                         out_hit
);

  // never holds off an item outside reset
  a_no_stall: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy high outside reset");

  // every accepted item produces a strobe
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item produced no strobe");

  // no strobe without an accepted item behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("strobe without accepted item");

  // circle centered on the box center always hits
  a_center_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_circle_x == in_box_x && in_circle_y == in_box_y)
      |-> ##LATENCY (out_valid && out_hit))
    else $error("concentric item reported a miss");

endmodule

bind circle_rotated_rect_collision crr_checker u_crr_checker (.*);

// ===== test/tb_circle_rotated_rect_collision.sv =====
// Self-checking testbench for the circle versus rotated rectangle hit test.
`timescale 1ns / 1ps

module tb_circle_rotated_rect_collision import crr_pkg::*; ();

  localparam int CLK_HALF     = 10;   // 20 ns period
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_LIMIT  = 2000; // cycles allowed for the pipeline to empty

  // One circle/box pair as presented on the in_ ports.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [EXT_BITS-1:0]          radius;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic [EXT_BITS-1:0]          width;
    logic [EXT_BITS-1:0]          height;
    logic [ANGLE_BITS-1:0]        angle;
  } pair_t;

  // Quarter-wave sine, Q1.14, 64 steps per quarter turn plus the end point.
  localparam int SINE_Q14 [0:64] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801,
    3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
    6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
    9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
    11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
    13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
    15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
    16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
    16384
  };

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [COORD_BITS-1:0] in_circle_x;
  logic signed [COORD_BITS-1:0] in_circle_y;
  logic [EXT_BITS-1:0]          in_circle_radius;
  logic signed [COORD_BITS-1:0] in_box_x;
  logic signed [COORD_BITS-1:0] in_box_y;
  logic [EXT_BITS-1:0]          in_box_width;
  logic [EXT_BITS-1:0]          in_box_height;
  logic [ANGLE_BITS-1:0]        in_box_angle;
  logic                         out_valid;
  logic                         out_hit;

  // Expected hit flags, oldest first; results leave the pipeline in order.
  bit pending_hits[$];

  int items_sent;
  int results_seen;
  int hits_seen;
  int error_count;

  circle_rotated_rect_collision u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_circle_x      (in_circle_x),
    .in_circle_y      (in_circle_y),
    .in_circle_radius (in_circle_radius),
    .in_box_x         (in_box_x),
    .in_box_y         (in_box_y),
    .in_box_width     (in_box_width),
    .in_box_height    (in_box_height),
    .in_box_angle     (in_box_angle),
    .out_valid        (out_valid),
    .out_hit          (out_hit)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // ---------------------------------------------------------------------
  // Hit predictor
  // ---------------------------------------------------------------------

  // Position 0..16384 inside a quarter wave -> Q1.14 magnitude.
  // Upper bits pick the table step, low 8 bits interpolate (truncated).
  function automatic longint quarter_mag(input int unsigned pos);
    logic [6:0]  idx;
    int unsigned frac;
    idx  = 7'(pos >> 8);
    frac = pos & 32'd255;
    if (idx >= 7'd64) return longint'(SINE_Q14[64]);
    return longint'(SINE_Q14[idx]) +
           ((longint'(SINE_Q14[idx + 7'd1] - SINE_Q14[idx]) * longint'(frac)) >>> 8);
  endfunction

  // 16-bit phase of one turn -> signed Q1.14 sine.
  // Bit 14 mirrors the quarter, bit 15 flips the sign.
  function automatic longint phase_sine(input logic [15:0] phase);
    longint mag;
    if (phase[14]) mag = quarter_mag(32'd16384 - int'(phase[13:0]));
    else           mag = quarter_mag(int'(phase[13:0]));
    return phase[15] ? -mag : mag;
  endfunction

  // Distance from a local coordinate to the slab [-lim, lim].
  function automatic longint outside_by(input longint v, input longint lim);
    if (v > lim)  return v - lim;
    if (v < -lim) return v + lim;
    return 0;
  endfunction

  function automatic bit predict_hit(input pair_t p);
    logic [15:0] phase;
    logic [15:0] phase_cos;
    longint      s;
    longint      c;
    longint      dx;
    longint      dy;
    longint      lx;
    longint      ly;
    longint      ax;
    longint      ay;
    longint      r2;
    phase     = 16'(p.angle);
    phase_cos = phase + 16'h4000;
    s         = phase_sine(phase);
    c         = phase_sine(phase_cos);
    dx        = longint'($signed(p.cx)) - longint'($signed(p.bx));
    dy        = longint'($signed(p.cy)) - longint'($signed(p.by));
    // Rotate into the box frame: exact in Q.22, round to Q.9 with ties up.
    // In Q.9 the half extents are the raw width/height codes and the
    // radius is twice its raw code.
    lx = (dx * c + dy * s + 4096) >>> 13;
    ly = (dy * c - dx * s + 4096) >>> 13;
    ax = outside_by(lx, longint'(p.width));
    ay = outside_by(ly, longint'(p.height));
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    r2 = 2 * longint'(p.radius);
    // Either component beyond the radius is a clear miss.
    if (ax > r2 || ay > r2) return 1'b0;
    return (ax * ax + ay * ay) <= (r2 * r2);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic pair_t make_pair(input longint cx, input longint cy, input longint radius,
                                      input longint bx, input longint by, input longint width,
                                      input longint height, input longint angle);
    pair_t p;
    p.cx     = COORD_BITS'(cx);
    p.cy     = COORD_BITS'(cy);
    p.radius = EXT_BITS'(radius);
    p.bx     = COORD_BITS'(bx);
    p.by     = COORD_BITS'(by);
    p.width  = EXT_BITS'(width);
    p.height = EXT_BITS'(height);
    p.angle  = ANGLE_BITS'(angle);
    return p;
  endfunction

  // Present one item and hold it until the block takes it. start is left
  // high so a following item goes in back to back.
  task automatic send_item(input pair_t p);
    in_circle_x      <= p.cx;
    in_circle_y      <= p.cy;
    in_circle_radius <= p.radius;
    in_box_x         <= p.bx;
    in_box_y         <= p.by;
    in_box_width     <= p.width;
    in_box_height    <= p.height;
    in_box_angle     <= p.angle;
    start            <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hits.push_back(predict_hit(p));
    items_sent++;
  endtask

  // Sender gap; zero keeps start high for a back-to-back item.
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic wait_results_drained();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_hits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  // Circle placed near a box of random scale so hits and misses mix.
  function automatic pair_t rand_near_pair(input bit axis_aligned);
    pair_t  p;
    int     wb;
    int     hb;
    int     rb;
    longint span;
    longint ox;
    longint oy;
    wb       = $urandom_range(1, 22);
    hb       = $urandom_range(1, 22);
    rb       = $urandom_range(0, 22);
    p.width  = EXT_BITS'($urandom & ((32'd1 << wb) - 1));
    p.height = EXT_BITS'($urandom & ((32'd1 << hb) - 1));
    p.radius = EXT_BITS'($urandom & ((32'd1 << rb) - 1));
    p.bx     = COORD_BITS'($urandom);
    p.by     = COORD_BITS'($urandom);
    // A rotated box reaches about hw + hh along either axis.
    span     = (longint'(p.width) + longint'(p.height)) / 2 + longint'(p.radius) + 2;
    ox       = longint'($urandom_range(0, 32'(2 * span))) - span;
    oy       = longint'($urandom_range(0, 32'(2 * span))) - span;
    p.cx     = COORD_BITS'(longint'($signed(p.bx)) + ox);
    p.cy     = COORD_BITS'(longint'($signed(p.by)) + oy);
    p.angle  = axis_aligned ? ANGLE_BITS'($urandom_range(0, 3) << 14) : ANGLE_BITS'($urandom);
    return p;
  endfunction

  function automatic pair_t rand_any_pair();
    return make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every strobe must match the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_hit === 1'b1) hits_seen++;
      if (pending_hits.size() == 0) begin
        $error("result with nothing expected: hit actual %b", out_hit);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want) begin
          $error("hit mismatch: expected %b actual %b", want, out_hit);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  localparam longint CMAX = 64'sd8388607;   // largest signed coordinate
  localparam longint CMIN = -64'sd8388608;  // smallest signed coordinate
  localparam longint EMAX = 64'sd8388607;   // largest size / radius

  // Coordinates at the ends of their range, centers as far apart as they go or coincident.
  task automatic test_field_extremes();
    send_item(make_pair(CMIN, CMIN, EMAX, CMAX, CMAX, EMAX, EMAX, 0));
    send_item(make_pair(CMAX, CMAX, EMAX, CMIN, CMIN, EMAX, EMAX, 16'h8000));
    send_item(make_pair(CMAX, CMIN, 0, CMIN, CMAX, 0, 0, 16'hFFFF));
    send_item(make_pair(CMIN, CMIN, EMAX, CMIN, CMIN, EMAX, EMAX, 16'h2000));
    send_item(make_pair(CMAX, CMAX, 0, CMAX, CMAX, 0, 0, 16'h6000));
    // Large distance with the largest radius: decided before squaring.
    send_item(make_pair(CMAX, 0, EMAX, CMIN, 0, 0, 0, 0));
    idle_cycles(3);
  endtask

  // Quadrant edges and table interpolation.
  task automatic test_angle_quadrants();
    longint angles [8] = '{16'h0000, 16'h00FF, 16'h3FFF, 16'h4000, 16'h4001,
                           16'h8000, 16'hC000, 16'hFFFF};
    foreach (angles[i])
      send_item(make_pair(16'h0600, 16'h0180, 16'h0100, 0, 0, 16'h0400, 16'h0100, angles[i]));
    idle_cycles(2);
  endtask

  // Zero-size boxes and zero radius.
  task automatic test_degenerate_sizes();
    send_item(make_pair(16'h1234, -16'sh0456, 0, 16'h1234, -16'sh0456, 0, 0, 16'h1357));
    send_item(make_pair(1, 0, 0, 0, 0, 0, 0, 0));  // point vs point, one lsb off
    send_item(make_pair(1, 0, 1, 0, 0, 0, 0, 0));  // one lsb radius reaches it
    send_item(make_pair(0, 0, 0, 0, 0, 16'h0200, 16'h0200, 16'h1000)); // point inside
    idle_cycles(1);
  endtask

  // Circle grazing an edge: exact touch hits, one lsb farther misses.
  task automatic test_edge_contact();
    send_item(make_pair(16'h0200, 0, 16'h0100, 0, 0, 16'h0200, 16'h0200, 0));
    send_item(make_pair(16'h0201, 0, 16'h0100, 0, 0, 16'h0200, 16'h0200, 0));
    send_item(make_pair(0, 16'h0300, 16'h0100, 0, 0, 16'h0400, 16'h0200, 16'h4000));
    send_item(make_pair(0, 16'h0301, 16'h0100, 0, 0, 16'h0400, 16'h0200, 16'h4000));
    send_item(make_pair(-16'sh0200, 0, 16'h0100, 0, 0, 16'h0200, 16'h0200, 16'h8000));
    send_item(make_pair(-16'sh0201, 0, 16'h0100, 0, 0, 16'h0200, 16'h0200, 16'h8000));
  endtask

  // Sender pauses with results in flight, then resumes.
  task automatic test_drain_pause();
    wait_results_drained();
  endtask

  // Bursty random stream, mostly pairs placed near each other.
  task automatic test_random_stream(input int count);
    int    sent;
    int    burst;
    int    pick;
    pair_t p;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 32);
      for (int k = 0; k < burst && sent < count; k++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5)      p = rand_near_pair(1'b0);
        else if (pick == 6) p = rand_near_pair(1'b1);
        else                p = rand_any_pair();
        send_item(p);
        sent++;
      end
      // About a quarter of the bursts run straight into the next one.
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    int waited;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_circle_x      <= '0;
    in_circle_y      <= '0;
    in_circle_radius <= '0;
    in_box_x         <= '0;
    in_box_y         <= '0;
    in_box_width     <= '0;
    in_box_height    <= '0;
    in_box_angle     <= '0;
    items_sent       = 0;
    results_seen     = 0;
    hits_seen        = 0;
    error_count      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_angle_quadrants();
    test_degenerate_sizes();
    test_edge_contact();
    test_drain_pause();
    test_random_stream(RANDOM_ITEMS / 2);
    test_drain_pause();
    test_random_stream(RANDOM_ITEMS - RANDOM_ITEMS / 2);

    // Let the pipeline empty, then keep the clock running to catch stray strobes.
    start  <= 1'b0;
    waited = 0;
    while (pending_hits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_hits.size() != 0) begin
      $error("%0d expected results never arrived", pending_hits.size());
      error_count++;
    end

    $display("Run covered %0d pairs (field extremes, quadrant edges, zero sizes, edge contact,",
             items_sent);
    $display("bursty random stream): %0d results, %0d hits, %0d misses.",
             results_seen, hits_seen, results_seen - hits_seen);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
